[hdl/ufsf_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ufsf_pkg
// Types, constants and helpers shared by the UTF-8 sequence filter.
// ----------------------------------------------------------------------------
package ufsf_pkg;

   localparam int MAX_RESULTS = 4;

   localparam logic [2:0] LEN_BAD   = 3'd0;
   localparam logic [2:0] LEN_ONE   = 3'd1;
   localparam logic [2:0] LEN_TWO   = 3'd2;
   localparam logic [2:0] LEN_THREE = 3'd3;
   localparam logic [2:0] LEN_FOUR  = 3'd4;

   localparam logic [4:0]  MAX_PLANE    = 5'h10;
   localparam logic [11:0] NONCHAR_MASK = 12'hffe;
   localparam logic [11:0] FDXX_MASK    = 12'hf80;
   localparam logic [11:0] FDXX_CODE    = 12'hd80;
   localparam logic [6:0]  FDXX_LOW     = 7'h30;
   localparam logic [6:0]  FDXX_HIGH    = 7'h4f;
   localparam logic [11:0] SURR_MASK    = 12'hb00;
   localparam logic [11:0] SURR_CODE    = 12'h800;

   typedef struct packed {
      logic [2:0]       num;     // result items, 0..4
      logic             marker;  // single empty end marker
      logic             last;    // request closes the string
      logic [3:0][7:0]  bytes;   // emitted bytes, first in [0]
   } step_result_type;

   function automatic logic [2:0] lead_len(input logic [7:0] b);
      logic [2:0] len;
      if (b[7] == 1'b0)              len = LEN_ONE;
      else if (b[7:5] == 3'b110)     len = LEN_TWO;
      else if (b[7:4] == 4'b1110)    len = LEN_THREE;
      else if (b[7:3] == 5'b11110)   len = LEN_FOUR;
      else                           len = LEN_BAD;
      return len;
   endfunction

endpackage

[hdl/ufsf_ifs.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ufsf channel interfaces
// Valid/ready channels for requests, responses and the control register.
// ----------------------------------------------------------------------------
interface ufsf_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] in_byte;
   logic       end_of_string;

   modport source (output valid, output in_byte, output end_of_string, input ready);
   modport sink   (input valid, input in_byte, input end_of_string, output ready);
endinterface

interface ufsf_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] out_byte;
   logic       byte_present;
   logic       last_of_string;

   modport source (output valid, output out_byte, output byte_present,
                   output last_of_string, input ready);
   modport sink   (input valid, input out_byte, input byte_present,
                   input last_of_string, output ready);
endinterface

interface ufsf_csr_if;
   logic valid;
   logic ready;
   logic validate_enable;

   modport source (output valid, output validate_enable, input ready);
   modport sink   (input valid, input validate_enable, output ready);
endinterface

[hdl/ufsf_decoder.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ufsf_decoder
// Per-request UTF-8 check against the held partial character, or pass-through
// when validation is off; holds the pending lead/continuation bytes.
// ----------------------------------------------------------------------------
module ufsf_decoder
   import ufsf_pkg::*;
(
   input  logic            clock,
   input  logic            reset,
   input  logic            fire,
   input  logic            validate_enable,
   input  logic [7:0]      in_byte,
   input  logic            end_of_string,
   output step_result_type result
);

   logic [7:0]      pend_ff [3];
   logic [7:0]      pend_in [3];
   logic [1:0]      cnt_ff;
   logic [1:0]      cnt_in;

   logic [3:0][7:0] w;
   logic [2:0]      x_len;
   logic [2:0]      p_len;
   logic [2:0]      n;
   logic            is_cont;
   logic [4:0]      plane;
   logic [11:0]     yx;
   logic            three_ok;
   logic            four_ok;
   logic            early_rej;

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         w[i] = (2'(i) == cnt_ff) ? in_byte : pend_ff[i];
      end
      w[3] = in_byte;
   end

   assign x_len   = lead_len(in_byte);
   assign p_len   = lead_len(pend_ff[0]);
   assign n       = {1'b0, cnt_ff} + 3'd1;
   assign is_cont = (in_byte[7:6] == 2'b10);
   assign plane   = {w[0][2:0], w[1][5:4]};
   assign yx      = {w[1][5:0], w[2][5:0]};

   assign three_ok = !((w[0][3:0] == 4'hf &&
                        ((yx & NONCHAR_MASK) == NONCHAR_MASK ||
                         ((yx & FDXX_MASK) == FDXX_CODE &&
                          yx[6:0] >= FDXX_LOW && yx[6:0] <= FDXX_HIGH))) ||
                       (w[0][3:0] == 4'hd && (yx & SURR_MASK) == SURR_CODE));

   assign four_ok = !(w[1][3:0] == 4'hf && w[2][5:0] == 6'h3f && w[3][5:1] == 5'h1f);

   assign early_rej = (n == 3'd2) &&
                      ((p_len == LEN_THREE && w[0][3:0] == 4'h0 && !w[1][5]) ||
                       (p_len == LEN_FOUR && (plane == 5'd0 || plane > MAX_PLANE)));

   always_comb begin
      result  = '0;
      cnt_in  = cnt_ff;
      pend_in = pend_ff;
      if (!validate_enable) begin
         cnt_in = 2'd0;
         if (in_byte != 8'd0) begin
            result.num      = 3'd1;
            result.bytes[0] = in_byte;
         end
      end else if (in_byte != 8'd0) begin
         if (cnt_ff == 2'd0 || !is_cont) begin
            cnt_in = 2'd0;
            case (x_len)
               LEN_ONE: begin
                  result.num      = 3'd1;
                  result.bytes[0] = in_byte;
               end
               LEN_TWO: begin
                  if (in_byte[4:0] > 5'd1) begin
                     pend_in[0] = in_byte;
                     cnt_in     = 2'd1;
                  end
               end
               LEN_THREE, LEN_FOUR: begin
                  pend_in[0] = in_byte;
                  cnt_in     = 2'd1;
               end
               default: begin
                  cnt_in = 2'd0;
               end
            endcase
         end else if (early_rej) begin
            cnt_in = 2'd0;
         end else if (n >= p_len) begin
            cnt_in = 2'd0;
            if ((p_len != LEN_THREE || three_ok) && (p_len != LEN_FOUR || four_ok)) begin
               result.num   = n;
               result.bytes = w;
            end
         end else begin
            pend_in[cnt_ff] = in_byte;
            cnt_in          = cnt_ff + 2'd1;
         end
      end
      if (end_of_string || in_byte == 8'd0) begin
         cnt_in      = 2'd0;
         result.last = 1'b1;
         if (result.num == 3'd0) begin
            result.num    = 3'd1;
            result.marker = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= 2'd0;
      end else if (fire) begin
         cnt_ff <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (fire) begin
         pend_ff <= pend_in;
      end
   end

`ifndef NO_ASSERTIONS
   a_end_clears: assert property (@(posedge clock) disable iff (reset)
      fire && (end_of_string || in_byte == 8'd0) |=> cnt_ff == 2'd0)
      else $error("pending bytes kept past end of string");

   a_bypass_clears: assert property (@(posedge clock) disable iff (reset)
      fire && !validate_enable |=> cnt_ff == 2'd0)
      else $error("pending bytes kept in pass-through");
`endif

endmodule

[hdl/ufsf_serializer.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ufsf_serializer
// Result register: holds the bytes of one request and sends them one per
// cycle on the response channel while the response channel is ready.
// ----------------------------------------------------------------------------
module ufsf_serializer
   import ufsf_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              load,
   input  step_result_type   result,
   output logic              can_load,
   ufsf_rsp_if.source        rsp
);

   step_result_type data_ff;
   logic [2:0]      rem_ff;
   logic [1:0]      idx_ff;
   logic            take;

   assign take     = rsp.valid && rsp.ready;
   assign can_load = (rem_ff == 3'd0) || (rem_ff == 3'd1 && rsp.ready);

   assign rsp.valid          = (rem_ff != 3'd0);
   assign rsp.out_byte       = data_ff.bytes[idx_ff];
   assign rsp.byte_present   = !data_ff.marker;
   assign rsp.last_of_string = data_ff.last && (rem_ff == 3'd1);

   always_ff @(posedge clock) begin
      if (reset) begin
         rem_ff <= 3'd0;
         idx_ff <= 2'd0;
      end else if (load) begin
         rem_ff <= result.num;
         idx_ff <= 2'd0;
      end else if (take) begin
         rem_ff <= rem_ff - 3'd1;
         idx_ff <= idx_ff + 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         data_ff <= result;
      end
   end

`ifndef NO_ASSERTIONS
   a_rem_range: assert property (@(posedge clock) disable iff (reset)
      rem_ff <= 3'(MAX_RESULTS))
      else $error("response count out of range");

   a_marker_last: assert property (@(posedge clock) disable iff (reset)
      rsp.valid && data_ff.marker |-> rsp.last_of_string && rsp.out_byte == 8'd0)
      else $error("end marker malformed");
`endif

endmodule

[hdl/utf8_invalid_sequence_filter_top.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// utf8_invalid_sequence_filter_top
// Drops bytes of malformed UTF-8 characters from a byte stream.
//
//  channel  dir  handshake      payload
//  req_if   in   valid/ready    in_byte[7:0], end_of_string
//  rsp_if   out  valid/ready    out_byte[7:0], byte_present, last_of_string
//  csr_if   in   valid/ready    validate_enable
//
// One request per cycle enters while the result register can load; a request
// yields 0 to 4 responses, sent one per cycle while rsp_if is ready. Requests
// are registered in the request register, then in the result register.
// Synchronous reset clears the pipeline and held bytes; validation is on.
// A stalled response holds the request register, then the request channel.
// ----------------------------------------------------------------------------
module utf8_invalid_sequence_filter_top
   import ufsf_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   ufsf_req_if.sink    req_if,
   ufsf_rsp_if.source  rsp_if,
   ufsf_csr_if.sink    csr_if
);

   logic            validate_ff;
   logic            in_valid_ff;
   logic [7:0]      in_byte_ff;
   logic            eos_ff;
   logic            can_load;
   logic            fire;
   step_result_type result;

   assign fire          = in_valid_ff && can_load;
   assign req_if.ready  = !in_valid_ff || fire;
   assign csr_if.ready  = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         validate_ff <= 1'b1;
         in_valid_ff <= 1'b0;
      end else begin
         if (csr_if.valid) begin
            validate_ff <= csr_if.validate_enable;
         end
         if (req_if.valid && req_if.ready) begin
            in_valid_ff <= 1'b1;
         end else if (fire) begin
            in_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_if.valid && req_if.ready) begin
         in_byte_ff <= req_if.in_byte;
         eos_ff     <= req_if.end_of_string;
      end
   end

   ufsf_decoder u_decoder (
      .clock           (clock),
      .reset           (reset),
      .fire            (fire),
      .validate_enable (validate_ff),
      .in_byte         (in_byte_ff),
      .end_of_string   (eos_ff),
      .result          (result)
   );

   ufsf_serializer u_serializer (
      .clock    (clock),
      .reset    (reset),
      .load     (fire),
      .result   (result),
      .can_load (can_load),
      .rsp      (rsp_if)
   );

endmodule

[test/utf8_invalid_sequence_filter_top_test.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// utf8_invalid_sequence_filter_top_test
// Self-checking bench for the UTF-8 sequence filter. A short directed table
// covers the byte extremes, end-of-string handling, rejected and accepted
// character forms and pass-through mode. It is followed by random
// mostly-valid character streams with malformed and truncated sequences mixed
// in. The request side sends in bursts, the response side stalls on its own
// pattern and holds off once for a long stretch. Every response is compared
// field by field with the bit-accurate model or a directed row's expectation.
// ----------------------------------------------------------------------------
module utf8_invalid_sequence_filter_top_test;
   import ufsf_pkg::*;

   localparam int CYCLE_LIMIT     = 100000;
   localparam int DRAIN_CYCLES    = 8;
   localparam int LONG_HOLD       = 150;
   localparam int HOLD_AFTER_REQS = 120;
   localparam int DIR_ROWS        = 30;

   typedef enum logic {ROW_REQ, ROW_CFG} row_kind_type;
   typedef enum logic [1:0] {CHK_MODEL, CHK_NONE, CHK_ONE, CHK_MARK} row_check_type;

   typedef struct packed {
      logic [7:0] data;
      logic       present;
      logic       last;
   } out_item_type;

   typedef struct packed {
      logic [7:0] val;
      logic       eos;
   } in_item_type;

   typedef struct packed {
      row_kind_type  kind;
      logic [7:0]    val;
      logic          eos;
      row_check_type chk;
   } row_type;

   row_type dir_rows [0:DIR_ROWS-1] = '{
      '{ROW_REQ, 8'h41, 1'b0, CHK_ONE},
      '{ROW_REQ, 8'h00, 1'b0, CHK_MARK},
      '{ROW_REQ, 8'h7f, 1'b1, CHK_ONE},
      '{ROW_REQ, 8'hff, 1'b1, CHK_MARK},
      '{ROW_REQ, 8'h80, 1'b0, CHK_NONE},
      '{ROW_REQ, 8'hc1, 1'b0, CHK_NONE},
      '{ROW_REQ, 8'hc2, 1'b0, CHK_MODEL},
      '{ROW_REQ, 8'ha9, 1'b0, CHK_MODEL},
      '{ROW_REQ, 8'he0, 1'b0, CHK_MODEL},
      '{ROW_REQ, 8'h80, 1'b0, CHK_MODEL},
      '{ROW_REQ, 8'hef, 1'b0, CHK_MODEL},
      '{ROW_REQ, 8'hbf, 1'b0, CHK_MODEL},
      '{ROW_REQ, 8'hbf, 1'b1, CHK_MODEL},
      '{ROW_REQ, 8'hed, 1'b0, CHK_MODEL},
      '{ROW_REQ, 8'ha0, 1'b0, CHK_MODEL},
      '{ROW_REQ, 8'h80, 1'b0, CHK_MODEL},
      '{ROW_REQ, 8'hf0, 1'b0, CHK_MODEL},
      '{ROW_REQ, 8'h9f, 1'b0, CHK_MODEL},
      '{ROW_REQ, 8'h98, 1'b0, CHK_MODEL},
      '{ROW_REQ, 8'h80, 1'b0, CHK_MODEL},
      '{ROW_REQ, 8'hc3, 1'b0, CHK_MODEL},
      '{ROW_REQ, 8'h41, 1'b0, CHK_MODEL},
      '{ROW_REQ, 8'he2, 1'b0, CHK_MODEL},
      '{ROW_REQ, 8'h82, 1'b0, CHK_MODEL},
      '{ROW_REQ, 8'h00, 1'b0, CHK_MODEL},
      '{ROW_CFG, 8'h00, 1'b0, CHK_NONE},
      '{ROW_REQ, 8'hc2, 1'b0, CHK_ONE},
      '{ROW_REQ, 8'h00, 1'b0, CHK_MARK},
      '{ROW_REQ, 8'hff, 1'b1, CHK_ONE},
      '{ROW_CFG, 8'h01, 1'b0, CHK_NONE}
   };

   logic clock;
   logic reset;

   ufsf_req_if req_ch ();
   ufsf_rsp_if rsp_ch ();
   ufsf_csr_if csr_ch ();

   // filter model state
   logic       vld_en;
   logic [7:0] held [0:2];
   int         held_cnt;

   out_item_type step_out [$];
   out_item_type owed_q [$];
   in_item_type  stim_q [$];

   int n_req      = 0;
   int n_res      = 0;
   int n_str      = 0;
   int n_cfg      = 0;
   int err_cnt    = 0;
   int cycle_cnt  = 0;
   int burst_left = 0;

   utf8_invalid_sequence_filter_top u_top (
      .clock  (clock),
      .reset  (reset),
      .req_if (req_ch),
      .rsp_if (rsp_ch),
      .csr_if (csr_ch)
   );

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   always @(posedge clock) begin
      cycle_cnt++;
      if (cycle_cnt >= CYCLE_LIMIT) begin
         $display("timeout after %0d cycles", cycle_cnt);
         $display("utf8_invalid_sequence_filter_top: mismatch");
         $finish;
      end
   end

   // ---------------------------------------------------------------- model

   function automatic logic [2:0] char_len(input logic [7:0] b);
      logic [2:0] len;
      casez (b)
         8'b0???????: len = LEN_ONE;
         8'b110?????: len = LEN_TWO;
         8'b1110????: len = LEN_THREE;
         8'b11110???: len = LEN_FOUR;
         default:     len = LEN_BAD;
      endcase
      return len;
   endfunction

   function automatic void put_byte(input logic [7:0] b);
      step_out.push_back('{data: b, present: 1'b1, last: 1'b0});
   endfunction

   function automatic void start_char(input logic [7:0] x);
      logic [2:0] len;
      len = char_len(x);
      held_cnt = 0;
      if (len == LEN_ONE) begin
         put_byte(x);
      end else if (len != LEN_BAD && !(len == LEN_TWO && x[4:0] <= 5'd1)) begin
         held[0] = x;
         held_cnt = 1;
      end
   endfunction

   function automatic logic three_ok(input logic [7:0] w0, input logic [7:0] w1,
                                     input logic [7:0] w2);
      logic [11:0] yx;
      logic [6:0]  lx;
      yx = {w1[5:0], w2[5:0]};
      lx = yx[6:0];
      if (w0[3:0] == 4'hf && ((yx & NONCHAR_MASK) == NONCHAR_MASK ||
          ((yx & FDXX_MASK) == FDXX_CODE && lx >= FDXX_LOW && lx <= FDXX_HIGH)))
         return 1'b0;
      if (w0[3:0] == 4'hd && (yx & SURR_MASK) == SURR_CODE)
         return 1'b0;
      return 1'b1;
   endfunction

   function automatic void take_byte(input logic [7:0] x);
      logic [7:0] w [0:3];
      logic [2:0] len;
      logic [4:0] plane;
      logic       ok;
      int         n;
      int         i;
      if (held_cnt == 0 || x[7:6] != 2'b10) begin
         start_char(x);
         return;
      end
      for (i = 0; i < held_cnt; i++)
         w[i] = held[i];
      w[held_cnt] = x;
      n = held_cnt + 1;
      len = char_len(w[0]);
      if (n == 2) begin
         if (len == LEN_THREE && w[0][3:0] == 4'h0 && !w[1][5]) begin
            held_cnt = 0;
            return;
         end
         plane = {w[0][2:0], w[1][5:4]};
         if (len == LEN_FOUR && (plane == 5'd0 || plane > MAX_PLANE)) begin
            held_cnt = 0;
            return;
         end
      end
      if (n >= len) begin
         ok = 1'b1;
         if (len == LEN_THREE)
            ok = three_ok(w[0], w[1], w[2]);
         else if (len == LEN_FOUR)
            ok = !(w[1][3:0] == 4'hf && w[2][5:0] == 6'h3f && w[3][5:1] == 5'h1f);
         if (ok)
            for (i = 0; i < n; i++)
               put_byte(w[i]);
         held_cnt = 0;
         return;
      end
      held[held_cnt] = x;
      held_cnt++;
   endfunction

   // responses caused by one request, left in step_out
   function automatic void filter_step(input logic [7:0] b, input logic eos);
      step_out.delete();
      if (vld_en) begin
         if (b != 8'h00)
            take_byte(b);
      end else begin
         held_cnt = 0;
         if (b != 8'h00)
            put_byte(b);
      end
      if (eos || b == 8'h00) begin
         held_cnt = 0;
         if (step_out.size() == 0)
            step_out.push_back('{data: 8'h00, present: 1'b0, last: 1'b0});
         step_out[step_out.size() - 1].last = 1'b1;
      end
   endfunction

   // ---------------------------------------------------------------- drivers

   task automatic send_req(input logic [7:0] b, input logic eos,
                           input row_check_type chk);
      req_ch.valid <= 1'b1;
      req_ch.in_byte <= b;
      req_ch.end_of_string <= eos;
      @(posedge clock);
      while (!req_ch.ready)
         @(posedge clock);
      n_req++;
      filter_step(b, eos);
      case (chk)
         CHK_MODEL: foreach (step_out[i]) owed_q.push_back(step_out[i]);
         CHK_ONE:   owed_q.push_back('{data: b, present: 1'b1, last: eos});
         CHK_MARK:  owed_q.push_back('{data: 8'h00, present: 1'b0, last: 1'b1});
         default:   ;
      endcase
   endtask

   task automatic pace();
      int gap;
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 16);
         gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
         if (gap > 0) begin
            req_ch.valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
      burst_left--;
   endtask

   task automatic wait_idle();
      req_ch.valid <= 1'b0;
      while (owed_q.size() != 0)
         @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic csr_write(input logic en);
      csr_ch.valid <= 1'b1;
      csr_ch.validate_enable <= en;
      @(posedge clock);
      while (!csr_ch.ready)
         @(posedge clock);
      csr_ch.valid <= 1'b0;
      vld_en = en;
      n_cfg++;
   endtask

   // ---------------------------------------------------------------- stimulus

   function automatic void push_b(input logic [7:0] v);
      stim_q.push_back('{val: v, eos: 1'b0});
   endfunction

   function automatic logic [7:0] cont();
      return 8'h80 | 8'($urandom_range(0, 63));
   endfunction

   task automatic gen_char();
      int         first;
      int         r;
      int         k;
      logic [7:0] lead;
      first = stim_q.size();
      case ($urandom_range(0, 15))
         0, 1, 2: push_b(8'($urandom_range(1, 127)));
         3, 4: begin
            push_b(8'($urandom_range(8'hc2, 8'hdf)));
            push_b(cont());
         end
         5: begin
            push_b(8'($urandom_range(8'hc0, 8'hc1)));
            push_b(cont());
         end
         6, 7: begin
            push_b(8'($urandom_range(8'he0, 8'hef)));
            push_b(cont());
            push_b(cont());
         end
         8: begin
            case ($urandom_range(0, 3))
               0: begin
                  push_b(8'hef);
                  push_b(8'hbf);
                  push_b(8'hbe | 8'($urandom_range(0, 1)));
               end
               1: begin
                  push_b(8'hef);
                  push_b(8'hb6 | 8'($urandom_range(0, 1)));
                  push_b(cont());
               end
               2: begin
                  push_b(8'hed);
                  push_b(8'($urandom_range(8'ha0, 8'hbf)));
                  push_b(cont());
               end
               default: begin
                  push_b(8'he0);
                  push_b(8'($urandom_range(8'h80, 8'h9f)));
                  push_b(cont());
               end
            endcase
         end
         9, 10: begin
            push_b(8'($urandom_range(8'hf0, 8'hf4)));
            push_b(cont());
            push_b(cont());
            push_b(cont());
         end
         11: begin
            push_b(8'($urandom_range(8'hf0, 8'hf7)));
            push_b(cont() | 8'h0f);
            push_b(8'hbf);
            push_b(8'hbe | 8'($urandom_range(0, 1)));
         end
         12: push_b(cont());
         13: push_b(8'($urandom_range(8'hf8, 8'hff)));
         14: begin
            lead = 8'($urandom_range(8'hc2, 8'hf4));
            k = int'(char_len(lead)) - 1;
            push_b(lead);
            repeat ($urandom_range(0, k - 1)) push_b(cont());
         end
         default: push_b(8'($urandom_range(0, 255)));
      endcase
      r = $urandom_range(0, 19);
      if (r < 2)
         stim_q[stim_q.size() - 1].eos = 1'b1;
      else if (r == 2)
         stim_q.push_back('{val: 8'h00, eos: 1'($urandom_range(0, 1))});
      else if (r == 3)
         stim_q[$urandom_range(first, stim_q.size() - 1)].eos = 1'b1;
   endtask

   task automatic send_stream(input int n_bytes);
      stim_q.delete();
      while (stim_q.size() < n_bytes)
         gen_char();
      foreach (stim_q[i]) begin
         send_req(stim_q[i].val, stim_q[i].eos, CHK_MODEL);
         pace();
      end
   endtask

   // ---------------------------------------------------------------- receiver

   initial begin : rx_pacing
      int   span;
      int   mode;
      int   hold_left;
      int   tick;
      logic held_off;
      rsp_ch.ready = 1'b0;
      span = 0;
      mode = 0;
      hold_left = 0;
      tick = 0;
      held_off = 1'b0;
      while (reset !== 1'b0)
         @(posedge clock);
      forever begin
         @(posedge clock);
         tick++;
         if (!held_off && n_req >= HOLD_AFTER_REQS) begin
            held_off = 1'b1;
            hold_left = LONG_HOLD;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_ch.ready <= 1'b0;
         end else begin
            if (span == 0) begin
               mode = $urandom_range(0, 3);
               span = $urandom_range(20, 80);
            end
            span--;
            case (mode)
               0:       rsp_ch.ready <= 1'b1;
               1:       rsp_ch.ready <= 1'($urandom_range(0, 1));
               2:       rsp_ch.ready <= (tick % 4 == 0);
               default: rsp_ch.ready <= ($urandom_range(0, 4) != 0);
            endcase
         end
      end
   end

   always @(posedge clock) begin : rsp_check
      out_item_type want;
      if (!reset && rsp_ch.valid && rsp_ch.ready) begin
         n_res++;
         if (rsp_ch.last_of_string)
            n_str++;
         if (owed_q.size() == 0) begin
            err_cnt++;
            $display("%0t: unexpected response: expected none, actual %h/%b/%b", $time,
                     rsp_ch.out_byte, rsp_ch.byte_present, rsp_ch.last_of_string);
         end else begin
            want = owed_q.pop_front();
            if (rsp_ch.out_byte !== want.data) begin
               err_cnt++;
               $display("%0t: out_byte expected %h, actual %h", $time,
                        want.data, rsp_ch.out_byte);
            end
            if (rsp_ch.byte_present !== want.present) begin
               err_cnt++;
               $display("%0t: byte_present expected %b, actual %b", $time,
                        want.present, rsp_ch.byte_present);
            end
            if (rsp_ch.last_of_string !== want.last) begin
               err_cnt++;
               $display("%0t: last_of_string expected %b, actual %b", $time,
                        want.last, rsp_ch.last_of_string);
            end
         end
      end
   end

   // ---------------------------------------------------------------- main

   initial begin : stimulus
      int i;
      reset = 1'b1;
      req_ch.valid = 1'b0;
      req_ch.in_byte = 8'h00;
      req_ch.end_of_string = 1'b0;
      csr_ch.valid = 1'b0;
      csr_ch.validate_enable = 1'b0;
      vld_en = 1'b1;
      held_cnt = 0;
      repeat (6) @(posedge clock);
      reset <= 1'b0;

      for (i = 0; i < DIR_ROWS; i++) begin
         if (dir_rows[i].kind == ROW_CFG) begin
            wait_idle();
            csr_write(dir_rows[i].val[0]);
         end else begin
            send_req(dir_rows[i].val, dir_rows[i].eos, dir_rows[i].chk);
            pace();
         end
      end

      send_stream(80);
      wait_idle();
      csr_write(1'b0);
      send_stream(25);
      wait_idle();
      csr_write(1'b1);
      send_stream(75);
      wait_idle();

      $display("run: %0d requests, %0d responses over %0d strings, %0d register writes,",
               n_req, n_res, n_str, n_cfg);
      $display("     validation on and off, one response hold-off of %0d cycles",
               LONG_HOLD);
      if (err_cnt == 0)
         $display("utf8_invalid_sequence_filter_top: match");
      else
         $display("utf8_invalid_sequence_filter_top: mismatch");
      $finish;
   end

endmodule

[sim.f]
hdl/ufsf_pkg.sv
hdl/ufsf_ifs.sv
hdl/ufsf_decoder.sv
hdl/ufsf_serializer.sv
hdl/utf8_invalid_sequence_filter_top.sv
test/utf8_invalid_sequence_filter_top_test.sv
